// File: rtl/core/keypad_matrix_scanner_assert.svh
// Assertion macros for the keypad matrix scanner.
`ifndef KEYPAD_MATRIX_SCANNER_ASSERT_SVH
`define KEYPAD_MATRIX_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define KMS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/kms_pkg.sv
`default_nettype none

package kms_pkg;

    localparam int ROW_W       = 4;
    localparam int COL_W       = 4;
    localparam int KEY_W       = 5;
    localparam int SETTLE_W    = 10;
    localparam int HOLDOFF_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF = 1'b1;

    localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 10'd100;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = 16'd8192;
    localparam logic [SETTLE_W-1:0]  SETTLE_MAX    = '1;
    localparam logic [ROW_W-1:0]     ROWS_RELEASED = '1;

endpackage

`default_nettype wire

// File: rtl/core/kms_sample_if.sv
`default_nettype none

interface kms_sample_if;
    import kms_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_levels;
    logic             scan_request;

    modport source (output valid, output row_levels, output scan_request, input ready);
    modport sink   (input valid, input row_levels, input scan_request, output ready);
endinterface

`default_nettype wire

// File: rtl/core/kms_report_if.sv
`default_nettype none

interface kms_report_if;
    import kms_pkg::*;

    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column_drive;
    logic             wake;
    logic             scan_done;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output column_drive, output wake, output scan_done,
                    output key_code, input ready);
    modport sink   (input valid, input column_drive, input wake, input scan_done,
                    input key_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/keypad_matrix_scanner.sv
// The report for an accepted sample is held in the report register from the edge that accepts it.
// Throughput: one sample per cycle; the report register frees as it is taken,
// so samples flow back to back unless the report side stalls.
// Reset (rst_n, async, active low): idle, lockout clear, rows seen as released,
// settle_ticks 100, holdoff_ticks 8192, no report held; column drive is not reset.
`default_nettype none

module keypad_matrix_scanner #(
    parameter int COLUMNS = 4,
    parameter int ROWS    = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [kms_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [kms_pkg::CFG_DATA_W-1:0]   cfg_data,
    kms_sample_if.sink                            sample,
    kms_report_if.source                          report
);
    import kms_pkg::*;

    localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic [CIDX_W-1:0] LAST_COL = CIDX_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_MASK = ROW_W'((1 << ROWS) - 1);
    localparam logic [COL_W-1:0]  COL_ALL  = COL_W'((1 << COLUMNS) - 1);
    localparam int KSUM_W = 8;

    logic [SETTLE_W-1:0]  settle_ticks_reg;
    logic [HOLDOFF_W-1:0] holdoff_ticks_reg;

    logic                 scanning_reg, scanning_next;
    logic [CIDX_W-1:0]    col_reg, col_next;
    logic [SETTLE_W-1:0]  settle_reg, settle_next;
    logic                 lock_reg, lock_next;
    logic [HOLDOFF_W-1:0] holdoff_reg, holdoff_next;
    logic [ROW_W-1:0]     prev_rows_reg;

    logic                 rpt_valid_reg;
    logic [COL_W-1:0]     drive_reg, drive_next;
    logic                 wake_reg, wake_next;
    logic                 done_reg, done_next;
    logic [KEY_W-1:0]     key_reg, key_next;

    logic                 accept;
    logic [ROW_W-1:0]     falling;
    logic [ROW_W-1:0]     low_rows;
    logic [SETTLE_W-1:0]  settle_inc;
    logic                 found;
    logic [1:0]           hit_row;
    logic [KSUM_W-1:0]    key_sum;

    assign sample.ready = !rpt_valid_reg || report.ready;
    assign accept       = sample.valid && sample.ready;

    assign falling    = prev_rows_reg & ~sample.row_levels & ROW_MASK;
    assign low_rows   = ~sample.row_levels & ROW_MASK;
    assign settle_inc = (settle_reg < SETTLE_MAX) ? settle_reg + 1'b1 : settle_reg;
    assign key_sum    = KSUM_W'(hit_row) + KSUM_W'(col_reg) * KSUM_W'(ROWS) + KSUM_W'(1);

    always_comb
    begin
        found   = 1'b0;
        hit_row = '0;
        for (int r = ROW_W - 1; r >= 0; r--)
        begin
            if (low_rows[r])
            begin
                found   = 1'b1;
                hit_row = 2'(r);
            end
        end
    end

    always_comb
    begin
        lock_next     = lock_reg;
        holdoff_next  = holdoff_reg;
        wake_next     = 1'b0;
        scanning_next = scanning_reg;
        col_next      = col_reg;
        settle_next   = settle_reg;
        done_next     = 1'b0;
        key_next      = '0;

        if ((falling != '0) && !lock_reg)
        begin
            wake_next    = 1'b1;
            lock_next    = 1'b1;
            holdoff_next = holdoff_ticks_reg;
        end
        else if (lock_reg)
        begin
            if (holdoff_reg <= HOLDOFF_W'(1))
            begin
                holdoff_next = '0;
                lock_next    = 1'b0;
            end
            else
            begin
                holdoff_next = holdoff_reg - 1'b1;
            end
        end

        if (!scanning_reg)
        begin
            if (sample.scan_request)
            begin
                scanning_next = 1'b1;
                col_next      = '0;
                settle_next   = '0;
            end
        end
        else
        begin
            settle_next = settle_inc;
            if (settle_inc >= settle_ticks_reg)
            begin
                if (found)
                begin
                    done_next = 1'b1;
                    key_next  = key_sum[KEY_W-1:0];
                end
                else if (col_reg == LAST_COL)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    col_next    = col_reg + 1'b1;
                    settle_next = '0;
                end
                if (done_next)
                begin
                    scanning_next = 1'b0;
                    col_next      = '0;
                    settle_next   = '0;
                end
            end
        end

        drive_next = scanning_next ? (COL_W'(1) << col_next) : COL_ALL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg  <= SETTLE_RESET;
            holdoff_ticks_reg <= HOLDOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SETTLE:  settle_ticks_reg  <= cfg_data[SETTLE_W-1:0];
                REG_HOLDOFF: holdoff_ticks_reg <= cfg_data[HOLDOFF_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg  <= 1'b0;
            col_reg       <= '0;
            settle_reg    <= '0;
            lock_reg      <= 1'b0;
            holdoff_reg   <= '0;
            prev_rows_reg <= ROWS_RELEASED;
        end
        else if (accept)
        begin
            scanning_reg  <= scanning_next;
            col_reg       <= col_next;
            settle_reg    <= settle_next;
            lock_reg      <= lock_next;
            holdoff_reg   <= holdoff_next;
            prev_rows_reg <= sample.row_levels;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            rpt_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive_next;
            wake_reg  <= wake_next;
            done_reg  <= done_next;
            key_reg   <= key_next;
        end
    end

    assign report.valid        = rpt_valid_reg;
    assign report.column_drive = drive_reg;
    assign report.wake         = wake_reg;
    assign report.scan_done    = done_reg;
    assign report.key_code     = key_reg;

    `include "keypad_matrix_scanner_assert.svh"

    `KMS_ASSERT_IMPLY(a_key_only_on_done, rpt_valid_reg && (key_reg != '0), done_reg, "key without scan_done")
    `KMS_ASSERT_NEXT(a_wake_sets_lock, accept && wake_next, lock_reg, "wake without lockout")
    `KMS_ASSERT_IMPLY(a_idle_counters_clear, !scanning_reg, (col_reg == '0) && (settle_reg == '0), "idle with live scan counters")
    `KMS_ASSERT_IMPLY(a_done_ends_scan, rpt_valid_reg && done_reg, drive_reg == COL_ALL, "scan_done with a single column driven")

endmodule

`default_nettype wire
